[hdl/csq_pkg.sv]
// Shared types and constants for the counting semaphore with wait queue.
`default_nettype none
package csq_pkg;

    // Default sizes
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int ID_BITS_DEF     = 8;

    // Count range and register map
    localparam int COUNT_BITS = 16;
    localparam int INIT_BITS  = 8;
    localparam int PADDR_BITS = 3;
    localparam int PDATA_BITS = 32;
    localparam logic [PADDR_BITS-1:0] ADDR_INITIAL_COUNT = 3'd0;
    localparam logic [INIT_BITS-1:0]  INITIAL_COUNT_RST  = 8'd1;

    localparam logic signed [COUNT_BITS-1:0] COUNT_MAX = 16'sh7FFF;
    localparam logic signed [COUNT_BITS-1:0] COUNT_MIN = 16'sh8000;

    // Request codes
    typedef enum logic {
        REQ_WAIT   = 1'b0,
        REQ_SIGNAL = 1'b1
    } t_req;

    // Queue command from the control logic to the cell chain
    typedef struct packed {
        logic push;
        logic pop;
    } t_queue_cmd;

    // Queue status back to the control logic
    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

endpackage
`default_nettype wire

[hdl/counting_semaphore_wait_queue.sv]
// Top level: semaphore count, request handling, output skid and APB register.
//
// Usage: a request (req type, requester id) enters on the i_in_valid /
// o_in_ready channel; each request gives exactly one result on the
// o_out_valid / i_out_ready channel (blocked, overflow drop, woken id,
// empty error and the count after the request).
// An accepted request's result is registered in the output register, or
// in the skid register if an untaken result is held. Throughput, while
// o_in_ready is high, is one request per cycle, set by the single count update and one-step cell shift.
// A wait that drives the count negative pushes its id into the first free
// cell; a signal that leaves the count at or below zero pops cell 0.
// Reset loads the count from initial_count (reset value 1) and empties the
// queue. Writing initial_count over APB reloads the count only.
// When the receiver stalls, one further request is taken into a skid
// register; o_in_ready then drops until the held result moves out.
`default_nettype none
module counting_semaphore_wait_queue
    import csq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int ID_BITS     = ID_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // Request channel
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic                  i_req_type,
    input  wire logic [ID_BITS-1:0]    i_requester_id,
    // Result channel
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic                       o_blocked,
    output logic                       o_overflow_drop,
    output logic                       o_woke_valid,
    output logic [ID_BITS-1:0]         o_woke_id,
    output logic                       o_empty_error,
    output logic signed [COUNT_BITS-1:0] o_count_now,
    // Configuration port
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [PADDR_BITS-1:0] paddr,
    input  wire logic [PDATA_BITS-1:0] pwdata,
    output logic [PDATA_BITS-1:0]      prdata,
    output logic                       pready
);

    localparam int RES_BITS = 4 + ID_BITS + COUNT_BITS;

    logic [INIT_BITS-1:0]          r_init;
    logic signed [COUNT_BITS-1:0]  r_count;
    logic signed [COUNT_BITS-1:0]  n_count;
    logic                          r_out_valid;
    logic                          r_skid_valid;
    logic [RES_BITS-1:0]           r_out;
    logic [RES_BITS-1:0]           r_skid;
    logic [RES_BITS-1:0]           w_result;
    logic                          w_accept;
    logic                          w_take;
    logic                          w_cfg_write;
    logic                          w_blocked;
    logic                          w_ovf;
    logic                          w_woke;
    logic                          w_empty_err;
    logic [ID_BITS-1:0]            w_woke_id;
    t_queue_cmd                    w_cmd;
    t_queue_status                 w_status;
    logic [ID_BITS-1:0]            w_head_id;

    assign w_accept    = i_in_valid && o_in_ready;
    assign w_take      = r_out_valid && i_out_ready;
    assign w_cfg_write = psel && penable && pwrite && pready
                         && (paddr == ADDR_INITIAL_COUNT);

    // Work out the new count and the queue action for one request
    always_comb begin
        n_count     = r_count;
        w_blocked   = 1'b0;
        w_ovf       = 1'b0;
        w_woke      = 1'b0;
        w_empty_err = 1'b0;
        w_woke_id   = '0;
        w_cmd       = '0;
        if (t_req'(i_req_type) == REQ_WAIT) begin
            if (r_count != COUNT_MIN) begin
                n_count = r_count - 16'sd1;
            end
            if (n_count < 0) begin
                if (w_status.full) begin
                    w_ovf = 1'b1;
                end else begin
                    w_blocked = 1'b1;
                    w_cmd.push = w_accept;
                end
            end
        end else begin
            if (r_count != COUNT_MAX) begin
                n_count = r_count + 16'sd1;
            end
            if (n_count <= 0) begin
                if (w_status.empty) begin
                    w_empty_err = 1'b1;
                end else begin
                    w_woke    = 1'b1;
                    w_woke_id = w_head_id;
                    w_cmd.pop = w_accept;
                end
            end
        end
    end

    assign w_result = {w_blocked, w_ovf, w_woke, w_empty_err, w_woke_id, n_count};

    csq_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_BITS     (ID_BITS)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .i_push_id (i_requester_id),
        .o_status  (w_status),
        .o_head_id (w_head_id)
    );

    // Hold the register and the count; a register write reloads the count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init  <= INITIAL_COUNT_RST;
            r_count <= COUNT_BITS'(INITIAL_COUNT_RST);
        end else if (w_cfg_write) begin
            r_init  <= pwdata[INIT_BITS-1:0];
            r_count <= COUNT_BITS'(pwdata[INIT_BITS-1:0]);
        end else if (w_accept) begin
            r_count <= n_count;
        end
    end

    // Advance results through the output register and the skid register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_take) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else if (!w_accept) begin
                r_out_valid <= 1'b0;
            end
        end else if (w_accept) begin
            if (r_out_valid) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (w_accept) begin
                r_out <= w_result;
            end
        end else if (w_accept) begin
            if (r_out_valid) begin
                r_skid <= w_result;
            end else begin
                r_out <= w_result;
            end
        end
    end

    assign o_in_ready  = !r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign {o_blocked, o_overflow_drop, o_woke_valid, o_empty_error, o_woke_id,
            o_count_now} = r_out;

    // Register read-back
    always_comb begin
        prdata = '0;
        if (paddr == ADDR_INITIAL_COUNT) begin
            prdata = PDATA_BITS'(r_init);
        end
    end

    assign pready = 1'b1;

endmodule
`default_nettype wire

[hdl/csq_cell.sv]
// One slot of the wait queue: holds an id and passes it toward the head.
`default_nettype none
module csq_cell
    import csq_pkg::*;
#(
    parameter int ID_BITS = ID_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_queue_cmd         i_cmd,
    input  wire logic [ID_BITS-1:0] i_push_id,
    input  wire logic               i_prev_valid,
    input  wire logic               i_next_valid,
    input  wire logic [ID_BITS-1:0] i_next_id,
    output logic                    o_valid,
    output logic [ID_BITS-1:0]      o_id
);

    logic               r_valid;
    logic [ID_BITS-1:0] r_id;
    logic               n_valid;
    logic [ID_BITS-1:0] n_id;

    // Pop takes the neighbor's entry; push fills the first free slot
    always_comb begin
        n_valid = r_valid;
        n_id    = r_id;
        if (i_cmd.pop) begin
            n_valid = i_next_valid;
            n_id    = i_next_id;
        end else if (i_cmd.push && !r_valid && i_prev_valid) begin
            n_valid = 1'b1;
            n_id    = i_push_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id <= n_id;
    end

    assign o_valid = r_valid;
    assign o_id    = r_id;

endmodule
`default_nettype wire

[hdl/csq_queue.sv]
// Wait queue built as a row of cells; cell 0 is the head.
`default_nettype none
module csq_queue
    import csq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int ID_BITS     = ID_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_queue_cmd         i_cmd,
    input  wire logic [ID_BITS-1:0] i_push_id,
    output t_queue_status           o_status,
    output logic [ID_BITS-1:0]      o_head_id
);

    logic [QUEUE_DEPTH-1:0] w_valid;
    logic [ID_BITS-1:0]     w_id [QUEUE_DEPTH];

    // Chain the cells; the ends see a full left edge and an empty right edge
    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        logic               w_prev_valid;
        logic               w_next_valid;
        logic [ID_BITS-1:0] w_next_id;

        if (i == 0) begin : g_head
            assign w_prev_valid = 1'b1;
        end else begin : g_body
            assign w_prev_valid = w_valid[i-1];
        end

        if (i == QUEUE_DEPTH-1) begin : g_tail
            assign w_next_valid = 1'b0;
            assign w_next_id    = '0;
        end else begin : g_link
            assign w_next_valid = w_valid[i+1];
            assign w_next_id    = w_id[i+1];
        end

        csq_cell #(
            .ID_BITS (ID_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (i_cmd),
            .i_push_id    (i_push_id),
            .i_prev_valid (w_prev_valid),
            .i_next_valid (w_next_valid),
            .i_next_id    (w_next_id),
            .o_valid      (w_valid[i]),
            .o_id         (w_id[i])
        );
    end

    // Report fill state and the oldest id
    assign o_status.full  = w_valid[QUEUE_DEPTH-1];
    assign o_status.empty = !w_valid[0];
    assign o_head_id      = w_id[0];

endmodule
`default_nettype wire
